FILE: hw/rtl/urd_pkg.sv
`default_nettype none

package urd_pkg;

    // Default echo counter width; the top level can override it.
    localparam int COUNT_WIDTH_DEF = 16;

    // Configuration register widths.
    localparam int TRIG_W  = 8;
    localparam int SCALE_W = 18;
    localparam int DWELL_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 18;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_TICKS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Q16     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DWELL_TICKS   = 2'd2;

    // Configuration values after reset.
    localparam logic [TRIG_W-1:0]  TRIGGER_TICKS_RST = 8'd10;
    localparam logic [SCALE_W-1:0] SCALE_Q16_RST     = 18'd112392;
    localparam logic [DWELL_W-1:0] DWELL_TICKS_RST   = 16'd1000;

    // Distance range and the Q16 reciprocal of ten used to split digits.
    localparam int DIST_W = 14;
    localparam logic [DIST_W-1:0] MAX_DISTANCE = 14'd9999;
    localparam int RECIP_W = 13;
    localparam logic [RECIP_W-1:0] RECIP_TEN_Q16 = 13'd6554;

    // Stream widths.
    localparam int S_DATA_W = 8;
    localparam int M_DATA_W = 32;
    localparam int DIGITS   = 4;

    // Commands from the sequencer to the datapath.
    typedef struct packed {
        logic       capture;
        logic       eval;
        logic       sat;
        logic       digit;
        logic [1:0] digit_idx;
        logic       emit;
    } urd_cmd_t;

    // Status from the datapath to the sequencer.
    typedef struct packed {
        logic latch;
        logic out_free;
    } urd_sts_t;

    // Seven-segment pattern, bit 0 = segment a through bit 6 = segment g.
    function automatic logic [6:0] seg_decode(input logic [3:0] digit);
        logic [6:0] seg;
        case (digit)
            4'd0: seg = 7'h3F;
            4'd1: seg = 7'h06;
            4'd2: seg = 7'h5B;
            4'd3: seg = 7'h4F;
            4'd4: seg = 7'h66;
            4'd5: seg = 7'h6D;
            4'd6: seg = 7'h7D;
            4'd7: seg = 7'h07;
            4'd8: seg = 7'h7F;
            4'd9: seg = 7'h6F;
            default: seg = 7'h00;
        endcase
        return seg;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/ultrasonic_range_display_core.sv
`default_nettype none

// Ultrasonic range finder with a multiplexed four-digit seven-segment display.
// The input stream carries one item per microsecond tick; s_tdata bit 0 is the
// sampled echo level. For every accepted item exactly one result item leaves on
// the m_ stream with the trigger level, the lit digit and its segment pattern,
// the last distance in hundredths of a centimetre, a new-reading flag and an
// over-range flag. Configuration (trigger length, Q16 scale, digit dwell) is
// written on the cfg_ channel, which is ready out of reset; the user must write
// it only while no item is in work, as the block itself does not enforce this.
// An ordinary tick is evaluated and then emitted into the output register. The
// tick on which the echo falls is also scaled by one multiplier, clipped at 9999
// and split into four decimal digits one per cycle by a shared reciprocal-of-ten
// step before it is emitted. One item is in work at a time, and s_tready rises
// again as the result is registered. A stalled receiver holds the result in the
// output register and the block waits with it. Reset returns to the trigger phase
// with a zero reading and the display on the hundredths digit, restores the
// configuration defaults, and s_tready rises on the first cycle after reset
// is released.
module ultrasonic_range_display_core #(
    parameter int COUNT_WIDTH = urd_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // s_tdata: bit 0 echo, bits 7:1 zero
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [urd_pkg::S_DATA_W-1:0]    s_tdata,
    // m_tdata: trigger [0], digit_select [2:1], segments [9:3], distance [23:10],
    // reading_done [24], over_range [25], zero [31:26]
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [urd_pkg::M_DATA_W-1:0]         m_tdata,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [urd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [urd_pkg::CFG_DATA_W-1:0]  cfg_data
);

    urd_pkg::urd_cmd_t cmd;
    urd_pkg::urd_sts_t sts;

    // Register writes are taken whenever the block is out of reset.
    assign cfg_ready = aresetn;

    urd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    urd_dpath #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

`default_nettype wire

FILE: hw/rtl/urd_ctrl.sv
`default_nettype none

module urd_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire urd_pkg::urd_sts_t  sts,
    output urd_pkg::urd_cmd_t       cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_SAT,
        ST_DIGIT,
        ST_EMIT
    } state_t;

    state_t     state_reg;
    logic [1:0] dig_cnt_reg;
    logic       s_tready_reg;

    assign s_tready = s_tready_reg;

    // Decode the commands for the current step.
    always_comb begin
        cmd           = '0;
        cmd.capture   = s_tready_reg & s_tvalid;
        cmd.eval      = (state_reg == ST_EVAL);
        cmd.sat       = (state_reg == ST_SAT);
        cmd.digit     = (state_reg == ST_DIGIT);
        cmd.digit_idx = dig_cnt_reg;
        cmd.emit      = (state_reg == ST_EMIT) & sts.out_free;
    end

    // Sequencer: evaluate the tick, convert a new reading if one is due, then emit.
    // The input is held not ready during reset and opens on the first idle cycle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            dig_cnt_reg  <= '0;
            s_tready_reg <= 1'b0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (s_tready_reg && s_tvalid) begin
                        state_reg    <= ST_EVAL;
                        s_tready_reg <= 1'b0;
                    end else begin
                        s_tready_reg <= 1'b1;
                    end
                end
                ST_EVAL: begin
                    state_reg <= sts.latch ? ST_SAT : ST_EMIT;
                end
                ST_SAT: begin
                    state_reg   <= ST_DIGIT;
                    dig_cnt_reg <= '0;
                end
                ST_DIGIT: begin
                    if (dig_cnt_reg == 2'd3) begin
                        state_reg <= ST_EMIT;
                    end
                    dig_cnt_reg <= dig_cnt_reg + 2'd1;
                end
                ST_EMIT: begin
                    if (sts.out_free) begin
                        state_reg    <= ST_IDLE;
                        s_tready_reg <= 1'b1;
                    end
                end
                default: begin
                    state_reg    <= ST_IDLE;
                    s_tready_reg <= 1'b1;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/urd_dpath.sv
`default_nettype none

module urd_dpath #(
    parameter int COUNT_WIDTH = urd_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic [urd_pkg::S_DATA_W-1:0]      s_tdata,
    input  wire logic                              cfg_valid,
    input  wire logic [urd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [urd_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire urd_pkg::urd_cmd_t                 cmd,
    output urd_pkg::urd_sts_t                      sts,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [urd_pkg::M_DATA_W-1:0]           m_tdata
);

    localparam int PROD_W = COUNT_WIDTH + urd_pkg::SCALE_W;
    localparam int FULL_W = PROD_W - 16;
    localparam int CPROD_W = urd_pkg::DIST_W + urd_pkg::RECIP_W;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

    localparam logic [1:0] PH_TRIGGER = 2'd0;
    localparam logic [1:0] PH_WAIT    = 2'd1;
    localparam logic [1:0] PH_COUNT   = 2'd2;

    // Configuration registers.
    logic [urd_pkg::TRIG_W-1:0]  trig_ticks_reg;
    logic [urd_pkg::SCALE_W-1:0] scale_reg;
    logic [urd_pkg::DWELL_W-1:0] dwell_ticks_reg;

    // Measurement state.
    logic                    echo_in_reg;
    logic [1:0]              phase_reg, phase_next;
    logic [7:0]              pulse_reg, pulse_next, pulse_inc;
    logic [COUNT_WIDTH-1:0]  echo_cnt_reg, echo_cnt_next;
    logic                    trig_reg, trig_next;
    logic                    done_reg;
    logic                    latch;

    // Conversion.
    logic [PROD_W-1:0]            prod_reg;
    logic [FULL_W-1:0]            dist_full;
    logic                         dist_sat;
    logic [urd_pkg::DIST_W-1:0]   dist_clip;
    logic [urd_pkg::DIST_W-1:0]   conv_reg;
    logic [CPROD_W-1:0]           conv_prod;
    logic [urd_pkg::DIST_W-1:0]   quot;
    logic [urd_pkg::DIST_W-1:0]   rem;
    logic [urd_pkg::DIST_W-1:0]   dist_reg;
    logic                         over_reg;
    logic [3:0]                   digit_reg [urd_pkg::DIGITS];

    // Display multiplexing and output register.
    logic [1:0]                   mux_reg;
    logic [urd_pkg::DWELL_W-1:0]  dwell_reg, dwell_inc;
    logic [6:0]                   seg;
    logic                         m_tvalid_reg;
    logic [urd_pkg::M_DATA_W-1:0] m_tdata_reg;

    assign m_tvalid     = m_tvalid_reg;
    assign m_tdata      = m_tdata_reg;
    assign sts.latch    = latch;
    assign sts.out_free = ~m_tvalid_reg | m_tready;

    // Configuration writes; an index beyond the list is ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            trig_ticks_reg  <= urd_pkg::TRIGGER_TICKS_RST;
            scale_reg       <= urd_pkg::SCALE_Q16_RST;
            dwell_ticks_reg <= urd_pkg::DWELL_TICKS_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                urd_pkg::CFG_TRIGGER_TICKS: trig_ticks_reg  <= cfg_data[urd_pkg::TRIG_W-1:0];
                urd_pkg::CFG_SCALE_Q16:     scale_reg       <= cfg_data[urd_pkg::SCALE_W-1:0];
                urd_pkg::CFG_DWELL_TICKS:   dwell_ticks_reg <= cfg_data[urd_pkg::DWELL_W-1:0];
                default: ;
            endcase
        end
    end

    // Next measurement state for one tick. An unused phase code acts as the trigger phase.
    always_comb begin
        phase_next    = phase_reg;
        pulse_next    = pulse_reg;
        echo_cnt_next = echo_cnt_reg;
        trig_next     = 1'b0;
        latch         = 1'b0;
        pulse_inc     = pulse_reg + 8'd1;
        case (phase_reg)
            PH_WAIT: begin
                if (echo_in_reg) begin
                    echo_cnt_next = COUNT_WIDTH'(1);
                    phase_next    = PH_COUNT;
                end
            end
            PH_COUNT: begin
                if (echo_in_reg) begin
                    if (echo_cnt_reg != CNT_MAX) begin
                        echo_cnt_next = echo_cnt_reg + COUNT_WIDTH'(1);
                    end
                end else begin
                    latch      = 1'b1;
                    pulse_next = '0;
                    phase_next = PH_TRIGGER;
                end
            end
            default: begin
                trig_next  = 1'b1;
                pulse_next = pulse_inc;
                if ((pulse_inc >= trig_ticks_reg) || (pulse_inc == 8'd0)) begin
                    pulse_next    = '0;
                    echo_cnt_next = '0;
                    phase_next    = PH_WAIT;
                end
            end
        endcase
    end

    // Capture the echo level and advance the measurement.
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            echo_in_reg <= s_tdata[0];
        end
        if (cmd.eval) begin
            prod_reg <= PROD_W'(echo_cnt_reg) * PROD_W'(scale_reg);
            trig_reg <= trig_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_TRIGGER;
            pulse_reg    <= '0;
            echo_cnt_reg <= '0;
            done_reg     <= 1'b0;
        end else if (cmd.eval) begin
            phase_reg    <= phase_next;
            pulse_reg    <= pulse_next;
            echo_cnt_reg <= echo_cnt_next;
            done_reg     <= latch;
        end
    end

    // Scale down, saturate and split into decimal digits one per cycle.
    assign dist_full = prod_reg[PROD_W-1:16];
    assign dist_sat  = dist_full > FULL_W'(urd_pkg::MAX_DISTANCE);
    assign dist_clip = dist_sat ? urd_pkg::MAX_DISTANCE : dist_full[urd_pkg::DIST_W-1:0];
    assign conv_prod = CPROD_W'(conv_reg) * CPROD_W'(urd_pkg::RECIP_TEN_Q16);
    assign quot      = urd_pkg::DIST_W'(conv_prod >> 16);
    assign rem       = conv_reg - (quot << 3) - (quot << 1);

    always_ff @(posedge aclk) begin
        if (cmd.sat) begin
            conv_reg <= dist_clip;
        end else if (cmd.digit) begin
            conv_reg <= quot;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dist_reg     <= '0;
            over_reg     <= 1'b0;
            digit_reg[0] <= '0;
            digit_reg[1] <= '0;
            digit_reg[2] <= '0;
            digit_reg[3] <= '0;
        end else begin
            if (cmd.sat) begin
                dist_reg <= dist_clip;
                over_reg <= dist_sat;
            end
            if (cmd.digit) begin
                digit_reg[cmd.digit_idx] <= rem[3:0];
            end
        end
    end

    // Build the result item and step the display multiplexer.
    assign seg       = urd_pkg::seg_decode(digit_reg[mux_reg]);
    assign dwell_inc = dwell_reg + urd_pkg::DWELL_W'(1);

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_tdata_reg <= {6'd0, over_reg, done_reg, dist_reg, seg, mux_reg, trig_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
            mux_reg      <= '0;
            dwell_reg    <= '0;
        end else begin
            if (cmd.emit) begin
                m_tvalid_reg <= 1'b1;
                if ((dwell_inc >= dwell_ticks_reg) || (dwell_inc == '0)) begin
                    dwell_reg <= '0;
                    mux_reg   <= mux_reg + 2'd1;
                end else begin
                    dwell_reg <= dwell_inc;
                end
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire
